FILE: hdl/pgf_pkg.sv
// Shared widths, limits and side-band types for the pairwise gravity force pipeline
package pgf_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 16;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned MASS_W  = 32;
  localparam int unsigned SCALE_W = 32;
  localparam int unsigned FORCE_W = 48;
  localparam int unsigned DIST_W  = 32;

  localparam int unsigned DIFF_W  = COORD_W + 1;           // |dx|, |dy|
  localparam int unsigned SQ_W    = 2 * DIFF_W;            // dx^2 + dy^2
  localparam int unsigned GM_W    = SCALE_W + MASS_W;
  localparam int unsigned PROD_W  = GM_W + MASS_W;         // g * m1 * m2
  localparam int unsigned ROOT_W  = SQ_W / 2;
  localparam int unsigned QA_W    = FORCE_W;               // mag / r, below 2^48
  localparam int unsigned HALF_W  = QA_W / 2;
  localparam int unsigned PL_W    = HALF_W + DIFF_W;
  localparam int unsigned PR_W    = ROOT_W + DIFF_W;       // rem * |d|
  localparam int unsigned Q_W     = QA_W + DIFF_W + 1;     // a * |d| + frac

  localparam logic [FORCE_W-1:0] POS_LIMIT = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic [FORCE_W-1:0] NEG_LIMIT = {1'b1, {(FORCE_W-1){1'b0}}};

  typedef struct packed {
    logic [DIFF_W-1:0] adx;
    logic [DIFF_W-1:0] ady;
    logic              negx;
    logic              negy;
  } geom_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    geom_t             geom;
  } rg_t;

  typedef struct packed {
    logic big;    // mag / r is at least 2^48
    rg_t  rg;
  } arg_t;

  typedef struct packed {
    logic           neg;
    logic           nz;
    logic           clip;
    logic [Q_W-1:0] q;
  } lane_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    lane_t             lane;
  } comp_t;

endpackage

FILE: hdl/pgf_if.sv
// Valid/ready channel interfaces for body pairs and force results
interface pgf_pair_if;
  logic                                valid;
  logic                                ready;
  logic signed [pgf_pkg::COORD_W-1:0]  body_x;
  logic signed [pgf_pkg::COORD_W-1:0]  body_y;
  logic        [pgf_pkg::MASS_W-1:0]   body_mass;
  logic signed [pgf_pkg::COORD_W-1:0]  other_x;
  logic signed [pgf_pkg::COORD_W-1:0]  other_y;
  logic        [pgf_pkg::MASS_W-1:0]   other_mass;

  modport source (output valid, body_x, body_y, body_mass, other_x, other_y, other_mass,
                  input ready);
  modport sink   (input valid, body_x, body_y, body_mass, other_x, other_y, other_mass,
                  output ready);
endinterface

interface pgf_force_if;
  logic                                valid;
  logic                                ready;
  logic signed [pgf_pkg::FORCE_W-1:0]  force_x;
  logic signed [pgf_pkg::FORCE_W-1:0]  force_y;
  logic        [pgf_pkg::DIST_W-1:0]   distance;
  logic                                saturated;
  logic                                coincident;

  modport source (output valid, force_x, force_y, distance, saturated, coincident,
                  input ready);
  modport sink   (input valid, force_x, force_y, distance, saturated, coincident,
                  output ready);
endinterface

FILE: hdl/pgf_isqrt.sv
// Pipelined integer square root, one root bit per stage
module pgf_isqrt #(
  parameter int unsigned RW = pgf_pkg::SQ_W,
  parameter int unsigned SW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic [RW-1:0]       rad_i,
  input  logic [SW-1:0]       side_i,
  output logic                vld_o,
  output logic [RW/2-1:0]     root_o,
  output logic [SW-1:0]       side_o
);

  localparam int unsigned HW  = RW / 2;
  localparam int unsigned RMW = HW + 2;
  localparam int unsigned TW  = RMW + 2;

  logic [HW-1:0]  vld_q;
  logic [RW-1:0]  rad_q  [HW];
  logic [RMW-1:0] rem_q  [HW];
  logic [HW-1:0]  root_q [HW];
  logic [SW-1:0]  side_q [HW];

  for (genvar k = 0; k < HW; k++) begin : g_step
    logic          v_in;
    logic [RW-1:0]  rad_in;
    logic [RMW-1:0] rem_in;
    logic [HW-1:0]  root_in;
    logic [SW-1:0]  side_in;
    logic [TW-1:0]  trial;
    logic [TW:0]    diff;

    if (k == 0) begin : g_first
      assign v_in    = vld_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, rad_in[RW-1:RW-2]};
    assign diff  = {1'b0, trial} - (TW+1)'({root_in, 2'b01});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_in << 2;
        side_q[k] <= side_in;
        if (!diff[TW]) begin
          rem_q[k]  <= diff[RMW-1:0];
          root_q[k] <= {root_in[HW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= trial[RMW-1:0];
          root_q[k] <= {root_in[HW-2:0], 1'b0};
        end
      end
    end
  end

  assign vld_o  = vld_q[HW-1];
  assign root_o = root_q[HW-1];
  assign side_o = side_q[HW-1];

endmodule

FILE: hdl/pgf_div.sv
// Pipelined restoring divider, one quotient bit per stage
module pgf_div #(
  parameter int unsigned QW = 48,
  parameter int unsigned DW = 33,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [QW-1:0] num_i,   // low dividend bits, shifted in msb first
  input  logic [DW-1:0] rem_i,   // high dividend part, must be below den_i
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QW-1:0] quot_o,
  output logic [DW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  logic [QW-1:0] vld_q;
  logic [QW-1:0] nq_q   [QW];   // dividend bits out at the top, quotient bits in below
  logic [DW-1:0] rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic          v_in;
    logic [QW-1:0] nq_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic [DW+1:0] diff;

    if (k == 0) begin : g_first
      assign v_in    = vld_i;
      assign nq_in   = num_i;
      assign rem_in  = rem_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, nq_in[QW-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
        if (!diff[DW+1]) begin
          rem_q[k] <= diff[DW-1:0];
          nq_q[k]  <= {nq_in[QW-2:0], 1'b1};
        end else begin
          rem_q[k] <= trial[DW-1:0];
          nq_q[k]  <= {nq_in[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign quot_o = nq_q[QW-1];
  assign rem_o  = rem_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

FILE: hdl/pairwise_gravity_force.sv
// Pairwise 2D gravity force: top level pipeline from body pair to force components
// Takes one body pair per clock and returns one force beat per pair, in order. The path is a
// single stalling pipeline of 122 + (96 - FRACTION_BITS) register stages (202 at the default
// 16 fraction bits): three for differences and products, one per bit for the 33-bit square
// root, the (96 - FRACTION_BITS)-bit magnitude division, the 48-bit division by r and the
// 33-bit remainder divisions, plus a few add and output stages. Throughput is one pair per
// cycle; when the output is held off every stage holds and pair_i.ready drops.
// gravity_scale resets to 1 and should be written only while the pipeline is empty.
module pairwise_gravity_force #(
  parameter int unsigned FRACTION_BITS = pgf_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pgf_pkg::SCALE_W-1:0]   cfg_wdata_i,
  pgf_pair_if.sink                      pair_i,
  pgf_force_if.source                   force_o
);

  localparam int unsigned NW    = pgf_pkg::PROD_W - FRACTION_BITS;  // p >> FRACTION_BITS
  localparam int unsigned HI_W  = NW - pgf_pkg::QA_W;
  localparam int unsigned CW    = (HI_W > pgf_pkg::ROOT_W) ? HI_W : pgf_pkg::ROOT_W;
  localparam int unsigned SQS_W = NW + pgf_pkg::SQ_W + $bits(pgf_pkg::geom_t);
  localparam int unsigned DW_R  = pgf_pkg::ROOT_W;
  localparam int unsigned FW    = pgf_pkg::FORCE_W;
  localparam int unsigned DFW   = pgf_pkg::DIFF_W;

  logic adv;
  logic out_vld_q;

  assign adv          = !out_vld_q || force_o.ready;
  assign pair_i.ready = adv;

  // config register
  logic [pgf_pkg::SCALE_W-1:0] gscale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gscale_q <= pgf_pkg::SCALE_W'(1);
    end else if (cfg_we_i) begin
      gscale_q <= cfg_wdata_i;
    end
  end

  // stage 1: offsets and g * m1
  logic [DFW-1:0]          dx_w, dy_w;
  pgf_pkg::geom_t          geom_w;
  logic                    s1_vld_q;
  pgf_pkg::geom_t          s1_geom_q;
  logic [pgf_pkg::GM_W-1:0] s1_gm_q;
  logic [pgf_pkg::MASS_W-1:0] s1_m2_q;

  always_comb begin
    dx_w        = {pair_i.other_x[pgf_pkg::COORD_W-1], pair_i.other_x}
                - {pair_i.body_x[pgf_pkg::COORD_W-1], pair_i.body_x};
    dy_w        = {pair_i.other_y[pgf_pkg::COORD_W-1], pair_i.other_y}
                - {pair_i.body_y[pgf_pkg::COORD_W-1], pair_i.body_y};
    geom_w.negx = dx_w[DFW-1];
    geom_w.negy = dy_w[DFW-1];
    geom_w.adx  = dx_w[DFW-1] ? (DFW'(0) - dx_w) : dx_w;
    geom_w.ady  = dy_w[DFW-1] ? (DFW'(0) - dy_w) : dy_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= pair_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_geom_q <= geom_w;
      s1_gm_q   <= pgf_pkg::GM_W'(gscale_q) * pgf_pkg::GM_W'(pair_i.body_mass);
      s1_m2_q   <= pair_i.other_mass;
    end
  end

  // stage 2: squares and partial products of g * m1 * m2
  logic                     s2_vld_q;
  pgf_pkg::geom_t           s2_geom_q;
  logic [pgf_pkg::SQ_W-1:0] s2_sqx_q, s2_sqy_q;
  logic [pgf_pkg::GM_W-1:0] s2_plo_q, s2_phi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_geom_q <= s1_geom_q;
      s2_sqx_q  <= pgf_pkg::SQ_W'(s1_geom_q.adx) * pgf_pkg::SQ_W'(s1_geom_q.adx);
      s2_sqy_q  <= pgf_pkg::SQ_W'(s1_geom_q.ady) * pgf_pkg::SQ_W'(s1_geom_q.ady);
      s2_plo_q  <= pgf_pkg::GM_W'(s1_gm_q[pgf_pkg::MASS_W-1:0]) * pgf_pkg::GM_W'(s1_m2_q);
      s2_phi_q  <= pgf_pkg::GM_W'(s1_gm_q[pgf_pkg::GM_W-1:pgf_pkg::MASS_W])
                 * pgf_pkg::GM_W'(s1_m2_q);
    end
  end

  // stage 3: s = dx^2 + dy^2, numerator scaled down by the fraction bits
  logic [pgf_pkg::PROD_W-1:0] p_w;
  logic                       s3_vld_q;
  pgf_pkg::geom_t             s3_geom_q;
  logic [pgf_pkg::SQ_W-1:0]   s3_s_q;
  logic [NW-1:0]              s3_pn_q;

  assign p_w = {s2_phi_q, {pgf_pkg::MASS_W{1'b0}}} + pgf_pkg::PROD_W'(s2_plo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_geom_q <= s2_geom_q;
      s3_s_q    <= s2_sqx_q + s2_sqy_q;
      s3_pn_q   <= NW'(p_w >> FRACTION_BITS);
    end
  end

  // r = isqrt(s)
  logic                       sq_vld;
  logic [pgf_pkg::ROOT_W-1:0] sq_root;
  logic [SQS_W-1:0]           sq_side;
  logic [NW-1:0]              sq_pn;
  logic [pgf_pkg::SQ_W-1:0]   sq_s;
  pgf_pkg::geom_t             sq_geom;

  pgf_isqrt #(
    .RW (pgf_pkg::SQ_W),
    .SW (SQS_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s3_vld_q),
    .rad_i  (s3_s_q),
    .side_i ({s3_pn_q, s3_s_q, s3_geom_q}),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  assign {sq_pn, sq_s, sq_geom} = sq_side;

  // mag = floor(pn / s)
  pgf_pkg::rg_t  sq_rg;
  logic          md_vld;
  logic [NW-1:0] md_mag;
  pgf_pkg::rg_t  md_rg;

  assign sq_rg.root = sq_root;
  assign sq_rg.geom = sq_geom;

  pgf_div #(
    .QW (NW),
    .DW (pgf_pkg::SQ_W),
    .SW ($bits(pgf_pkg::rg_t))
  ) u_mag_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (sq_vld),
    .num_i  (sq_pn),
    .rem_i  ('0),
    .den_i  (sq_s),
    .side_i (sq_rg),
    .vld_o  (md_vld),
    .quot_o (md_mag),
    .rem_o  (),
    .side_o (md_rg)
  );

  // stage 4: split mag; a quotient mag / r of 2^48 or more is flagged to clip outright
  logic [HI_W-1:0]            mag_hi_w;
  logic                       big_w;
  logic                       s4_vld_q;
  pgf_pkg::arg_t              s4_arg_q;
  logic [DW_R-1:0]            s4_hi_q;
  logic [pgf_pkg::QA_W-1:0]   s4_lo_q;

  assign mag_hi_w = md_mag[NW-1:pgf_pkg::QA_W];
  assign big_w    = CW'(mag_hi_w) >= CW'(md_rg.root);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (adv) begin
      s4_vld_q <= md_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_arg_q.big <= big_w;
      s4_arg_q.rg  <= md_rg;
      s4_hi_q      <= big_w ? '0 : DW_R'(mag_hi_w);
      s4_lo_q      <= md_mag[pgf_pkg::QA_W-1:0];
    end
  end

  // a = mag / r with remainder
  logic                     ad_vld;
  logic [pgf_pkg::QA_W-1:0] ad_quot;
  logic [DW_R-1:0]          ad_rem;
  pgf_pkg::arg_t            ad_arg;
  pgf_pkg::arg_t            ad_arg_o;

  assign ad_arg = s4_arg_q;

  pgf_div #(
    .QW (pgf_pkg::QA_W),
    .DW (DW_R),
    .SW ($bits(pgf_pkg::arg_t))
  ) u_a_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s4_vld_q),
    .num_i  (s4_lo_q),
    .rem_i  (s4_hi_q),
    .den_i  (s4_arg_q.rg.root),
    .side_i (ad_arg),
    .vld_o  (ad_vld),
    .quot_o (ad_quot),
    .rem_o  (ad_rem),
    .side_o (ad_arg_o)
  );

  // stages 5 and 6 per axis: a * |d| in halves, rem * |d|, then sum the halves
  logic                       s5_vld_q, s6_vld_q;
  logic [DW_R-1:0]            s5_root_q, s6_root_q;
  logic [pgf_pkg::PL_W-1:0]   s5_pl_q [2];
  logic [pgf_pkg::PL_W-1:0]   s5_ph_q [2];
  logic [pgf_pkg::PR_W-1:0]   s5_pr_q [2];
  logic [1:0]                 s5_neg_q, s5_nz_q, s5_clip_q;
  pgf_pkg::lane_t             s6_lane_q [2];
  logic [pgf_pkg::PR_W-1:0]   s6_pr_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else if (adv) begin
      s5_vld_q <= ad_vld;
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_root_q <= ad_arg_o.rg.root;
      s6_root_q <= s5_root_q;
    end
  end

  // lane dividers: floor(rem * |d| / r)
  logic                   ld_vld  [2];
  logic [DW_R-1:0]        ld_quot [2];
  pgf_pkg::comp_t         ld_side [2];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [DFW-1:0]           ad_w;
    logic                     neg_w;
    logic [FW-1:0]            lim_w;
    pgf_pkg::comp_t           side_w;

    assign ad_w  = (l == 0) ? ad_arg_o.rg.geom.adx  : ad_arg_o.rg.geom.ady;
    assign neg_w = (l == 0) ? ad_arg_o.rg.geom.negx : ad_arg_o.rg.geom.negy;
    assign lim_w = neg_w ? pgf_pkg::NEG_LIMIT : pgf_pkg::POS_LIMIT;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        s5_pl_q[l]   <= pgf_pkg::PL_W'(ad_quot[pgf_pkg::HALF_W-1:0]) * pgf_pkg::PL_W'(ad_w);
        s5_ph_q[l]   <= pgf_pkg::PL_W'(ad_quot[pgf_pkg::QA_W-1:pgf_pkg::HALF_W])
                      * pgf_pkg::PL_W'(ad_w);
        s5_pr_q[l]   <= pgf_pkg::PR_W'(ad_rem) * pgf_pkg::PR_W'(ad_w);
        s5_neg_q[l]  <= neg_w;
        s5_nz_q[l]   <= ad_w != '0;
        s5_clip_q[l] <= ad_arg_o.big || (ad_quot > lim_w);

        s6_lane_q[l].neg  <= s5_neg_q[l];
        s6_lane_q[l].nz   <= s5_nz_q[l];
        s6_lane_q[l].clip <= s5_clip_q[l];
        s6_lane_q[l].q    <= (pgf_pkg::Q_W'(s5_ph_q[l]) << pgf_pkg::HALF_W)
                           + pgf_pkg::Q_W'(s5_pl_q[l]);
        s6_pr_q[l]        <= s5_pr_q[l];
      end
    end

    assign side_w.root = s6_root_q;
    assign side_w.lane = s6_lane_q[l];

    pgf_div #(
      .QW (DW_R),
      .DW (DW_R),
      .SW ($bits(pgf_pkg::comp_t))
    ) u_frac_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (s6_vld_q),
      .num_i  (s6_pr_q[l][DW_R-1:0]),
      .rem_i  (s6_pr_q[l][pgf_pkg::PR_W-1:DW_R]),
      .den_i  (s6_root_q),
      .side_i (side_w),
      .vld_o  (ld_vld[l]),
      .quot_o (ld_quot[l]),
      .rem_o  (),
      .side_o (ld_side[l])
    );
  end

  // stage 7: full quotient per axis
  logic            s7_vld_q;
  logic [DW_R-1:0] s7_root_q;
  pgf_pkg::lane_t  s7_lane_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else if (adv) begin
      s7_vld_q <= ld_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_root_q <= ld_side[0].root;
      for (int l = 0; l < 2; l++) begin
        s7_lane_q[l].neg  <= ld_side[l].lane.neg;
        s7_lane_q[l].nz   <= ld_side[l].lane.nz;
        s7_lane_q[l].clip <= ld_side[l].lane.clip;
        s7_lane_q[l].q    <= ld_side[l].lane.q + pgf_pkg::Q_W'(ld_quot[l]);
      end
    end
  end

  // output: clip, sign, flags
  logic [FW-1:0] frc_w [2];
  logic [1:0]    sat_w;

  always_comb begin
    logic [FW-1:0] lim;
    logic [FW-1:0] mag;
    for (int l = 0; l < 2; l++) begin
      lim      = s7_lane_q[l].neg ? pgf_pkg::NEG_LIMIT : pgf_pkg::POS_LIMIT;
      sat_w[l] = s7_lane_q[l].nz
               && (s7_lane_q[l].clip || (s7_lane_q[l].q > pgf_pkg::Q_W'(lim)));
      if (!s7_lane_q[l].nz) begin
        mag = '0;
      end else if (sat_w[l]) begin
        mag = lim;
      end else begin
        mag = s7_lane_q[l].q[FW-1:0];
      end
      frc_w[l] = s7_lane_q[l].neg ? (FW'(0) - mag) : mag;
    end
  end

  logic [FW-1:0]              fx_q, fy_q;
  logic [pgf_pkg::DIST_W-1:0] dist_q;
  logic                       sat_q, coinc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= s7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fx_q    <= frc_w[0];
      fy_q    <= frc_w[1];
      sat_q   <= |sat_w;
      coinc_q <= s7_root_q == '0;
      dist_q  <= s7_root_q[DW_R-1] ? '1 : s7_root_q[pgf_pkg::DIST_W-1:0];
    end
  end

  assign force_o.valid      = out_vld_q;
  assign force_o.force_x    = fx_q;
  assign force_o.force_y    = fy_q;
  assign force_o.distance   = dist_q;
  assign force_o.saturated  = sat_q;
  assign force_o.coincident = coinc_q;

  a_coinc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    force_o.valid && force_o.coincident |->
      force_o.force_x == '0 && force_o.force_y == '0 && !force_o.saturated
      && force_o.distance == '0)
    else $error("coincident beat with non-zero force or distance");

  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    force_o.valid && force_o.saturated |->
      force_o.force_x == pgf_pkg::POS_LIMIT || force_o.force_x == pgf_pkg::NEG_LIMIT
      || force_o.force_y == pgf_pkg::POS_LIMIT || force_o.force_y == pgf_pkg::NEG_LIMIT)
    else $error("saturated beat without a clipped component");

  a_dist_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    force_o.valid && !force_o.coincident |-> force_o.distance != '0)
    else $error("separate bodies reported at zero distance");

endmodule
